// File: sv/aliased_region_membership_test_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the aliased region membership test
// Concurrent checks sampled on clk, disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef ALIASED_REGION_MEMBERSHIP_TEST_MACROS_SVH
`define ALIASED_REGION_MEMBERSHIP_TEST_MACROS_SVH

// same-cycle implication
`define ARM_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ARM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/arm_pkg.sv
// ----------------------------------------------------------------------------
// arm_pkg
// Types and constants shared by the aliased region membership test.
// ----------------------------------------------------------------------------
`default_nettype none

package arm_pkg;

	// default fraction bits of positions and bounds
	localparam int FRACTION_BITS_DEF = 8;

	// fixed field widths
	localparam int POS_W = 32;
	localparam int CNT_W = 8;
	localparam int PER_W = 16;
	localparam int D2_W  = 63;

	// p - first always fits in 34 signed bits
	localparam int DVD_W = 34;

	// clamp value of the squared distance
	localparam logic [D2_W-1:0] SAT_D2 = D2_W'(1) << 62;

	typedef struct packed {
		logic signed [POS_W-1:0] position;
		logic signed [CNT_W-1:0] aliasing_count;
		logic signed [POS_W-1:0] window_first;
		logic signed [POS_W-1:0] window_last;
		logic [PER_W-1:0]        period_points;
		logic                    fold_allowed;
		logic                    final_dimension;
	} item_t;

	typedef struct packed {
		logic [D2_W-1:0] distance_squared;
		logic            dimension_inside;
		logic            peak_inside;
		logic            is_final;
	} result_t;

	// divider status toward the sequencer
	typedef struct packed {
		logic busy;
		logic done;
	} div_status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ADJ,
		ST_DIST,
		ST_SQR,
		ST_OUT
	} arm_state_t;

endpackage

`default_nettype wire

// File: sv/aliased_region_membership_test.sv
// Flow: an accepted beat passes the serial divider (only when folding with a
// nonzero period), then ADJ, DIST, SQR and OUT into the output register.
// A new beat is taken only once the result sits in the output register,
// which holds it while the consumer stalls.
// Reset: sequencer idle, no result pending, running peak AND set to 1.
// ----------------------------------------------------------------------------
// aliased_region_membership_test
// Per-dimension alias/fold of a peak position into a window, inside test,
// squared distance from the window center and running peak verdict.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aliased_region_membership_test_macros.svh"

module aliased_region_membership_test import arm_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	localparam int PQ_W  = PER_W + FRACTION_BITS;
	localparam int ADJ_W = (PQ_W + 10 > DVD_W) ? PQ_W + 10 : DVD_W;
	localparam int E_W   = ADJ_W + 2;
	localparam int PRD_W = PQ_W + CNT_W + 1;
	localparam int SQ_W  = 2 * POS_W;
	localparam logic signed [DVD_W-1:0] ONE_PT = DVD_W'(1) << FRACTION_BITS;

	arm_state_t state_q, state_d;

	logic accept;
	logic start_div;
	logic out_free;
	logic load_res;

	// input capture
	logic signed [DVD_W-1:0] p_in, dvd_in, p_q;
	logic [DVD_W-1:0]        mag_in;
	logic [PQ_W-1:0]         per_in, per_q;
	logic signed [POS_W-1:0] first_q, last_q;
	logic signed [CNT_W-1:0] cnt_q;
	logic                    fold_q, fin_q, neg_q;

	// datapath
	div_status_t             div_st;
	logic [PQ_W-1:0]         rem;
	logic [PQ_W-1:0]         rem_adj;
	logic signed [PRD_W-1:0] prod;
	logic signed [ADJ_W-1:0] fold_p, alias_p, padj_d, padj_q;
	logic signed [ADJ_W-1:0] first_x, last_x;
	logic                    inside_d, inside_q;
	logic signed [E_W-1:0]   e_d;
	logic [E_W-1:0]          a_full;
	logic [POS_W-1:0]        a_q;
	logic                    sat_q;
	logic [SQ_W-1:0]         sq_d, sq_q;

	logic    run_q;
	logic    res_valid_q;
	result_t res_q;

	// handshake terms
	assign accept    = item_valid && !item_stall;
	assign start_div = accept && item.fold_allowed && (item.period_points != '0);
	assign out_free  = !res_valid_q || !result_stall;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = start_div ? ST_DIV : ST_ADJ;
			end
			ST_DIV: begin
				if (div_st.done) state_d = ST_ADJ;
			end
			ST_ADJ:  state_d = ST_DIST;
			ST_DIST: state_d = ST_SQR;
			ST_SQR:  state_d = ST_OUT;
			ST_OUT: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		item_stall = 1'b1;
		load_res   = 1'b0;
		case (state_q)
			ST_IDLE: item_stall = 1'b0;
			ST_OUT:  load_res   = out_free;
			default: begin
				item_stall = 1'b1;
				load_res   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// 0-based position and signed offset from the window start
	always_comb begin
		p_in   = DVD_W'(item.position) - ONE_PT;
		dvd_in = p_in - DVD_W'(item.window_first);
		mag_in = dvd_in[DVD_W-1] ? DVD_W'(-dvd_in) : DVD_W'(dvd_in);
		per_in = PQ_W'(item.period_points) << FRACTION_BITS;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			p_q     <= p_in;
			first_q <= item.window_first;
			last_q  <= item.window_last;
			per_q   <= per_in;
			cnt_q   <= item.aliasing_count;
			fold_q  <= item.fold_allowed;
			fin_q   <= item.final_dimension;
			neg_q   <= dvd_in[DVD_W-1];
		end
	end

	arm_rem_div #(
		.PQ_W (PQ_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start_div),
		.dividend  (mag_in),
		.divisor   (per_q),
		.status    (div_st),
		.remainder (rem)
	);

	// adjusted position and inside test
	always_comb begin
		first_x = ADJ_W'(first_q);
		last_x  = ADJ_W'(last_q);
		// floor modulo from the magnitude remainder
		rem_adj = (neg_q && rem != '0) ? per_q - rem : rem;
		if (per_q == '0) fold_p = ADJ_W'(p_q);
		else             fold_p = first_x + $signed(ADJ_W'({1'b0, rem_adj}));
		prod    = PRD_W'(cnt_q) * PRD_W'($signed({1'b0, per_q}));
		alias_p = ADJ_W'(p_q) + ADJ_W'(prod);
		padj_d  = fold_q ? fold_p : alias_p;
		if (fold_q) inside_d = padj_d <= last_x;
		else        inside_d = (padj_d >= first_x) && (padj_d <= last_x);
	end

	// doubled distance from center, magnitude (source of the saturation flag), square
	always_comb begin
		e_d    = (E_W'(padj_q) <<< 1) - E_W'(first_q) - E_W'(last_q);
		a_full = e_d[E_W-1] ? E_W'(-e_d) : E_W'(e_d);
		sq_d   = SQ_W'(a_q) * SQ_W'(a_q);
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ADJ) begin
			padj_q   <= padj_d;
			inside_q <= inside_d;
		end
		if (state_q == ST_DIST) begin
			a_q   <= a_full[POS_W-1:0];
			sat_q <= |a_full[E_W-1:POS_W];
		end
		if (state_q == ST_SQR) begin
			sq_q <= sq_d;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q.distance_squared <= sat_q ? SAT_D2 : D2_W'(sq_q[SQ_W-1:2]);
			res_q.dimension_inside <= inside_q;
			res_q.peak_inside      <= run_q & inside_q;
			res_q.is_final         <= fin_q;
		end
	end

	// output valid and running peak AND
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			run_q       <= 1'b1;
		end else begin
			if (load_res)      res_valid_q <= 1'b1;
			else if (out_free) res_valid_q <= 1'b0;
			if (load_res)      run_q <= fin_q ? 1'b1 : (run_q & inside_q);
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

	`ARM_ASSERT_NOW(a_done_in_div, div_st.done, state_q == ST_DIV,
		"divider finished outside the divide state")
	`ARM_ASSERT_NOW(a_div_busy, (state_q == ST_DIV) && !div_st.done, div_st.busy,
		"divide state waits on an idle divider")
	`ARM_ASSERT_NEXT(a_accept_path, accept, (state_q == ST_DIV) || (state_q == ST_ADJ),
		"accepted beat did not start processing")
	`ARM_ASSERT_NEXT(a_sat_value, load_res && sat_q, result.distance_squared == SAT_D2,
		"saturated distance not clamped")
	`ARM_ASSERT_NEXT(a_run_reset, load_res && fin_q, run_q,
		"running peak AND not restored after final dimension")

endmodule

`default_nettype wire

// File: sv/arm_rem_div.sv
// ----------------------------------------------------------------------------
// arm_rem_div
// Serial restoring divider, one dividend bit per cycle, remainder only.
// The divisor must hold steady while busy.
// ----------------------------------------------------------------------------
`default_nettype none

module arm_rem_div import arm_pkg::*; #(
	parameter int PQ_W = PER_W + FRACTION_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DVD_W-1:0]  dividend,
	input  wire logic [PQ_W-1:0]   divisor,
	output div_status_t            status,
	output logic [PQ_W-1:0]        remainder
);

	localparam int STEP_W = $clog2(DVD_W + 1);

	logic [STEP_W-1:0] step_q;
	logic              busy_q;
	logic              done_q;
	logic [PQ_W-1:0]   rem_q;
	logic [DVD_W-1:0]  dvd_q;

	logic [PQ_W:0]     trial;
	logic [PQ_W:0]     diff;
	logic              fits;
	logic [PQ_W-1:0]   rem_d;

	// one restoring step: shift in next dividend bit, subtract if it fits
	always_comb begin
		trial = {rem_q, dvd_q[DVD_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = trial >= {1'b0, divisor};
		rem_d = fits ? diff[PQ_W-1:0] : trial[PQ_W-1:0];
	end

	// step control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= STEP_W'(DVD_W);
			end else if (busy_q) begin
				step_q <= step_q - STEP_W'(1);
				if (step_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// partial remainder and dividend shift register
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dvd_q <= dividend;
		end else if (busy_q) begin
			rem_q <= rem_d;
			dvd_q <= {dvd_q[DVD_W-2:0], 1'b0};
		end
	end

	assign status.busy = busy_q;
	assign status.done = done_q;
	assign remainder   = rem_q;

endmodule

`default_nettype wire

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives peak dimensions into the aliased region membership test, predicts
// the fold/alias adjustment, squared distance and running peak verdict for
// every accepted beat, and compares each result beat field by field in order.
// Directed corner cases come first, then random peaks with random gaps and
// stalls on both sides, one long consumer hold and drains midway and at the end.
// ----------------------------------------------------------------------------
module testbench import arm_pkg::*; ();

	localparam int RANDOM_ITEMS  = 800;
	localparam int HOLD_AT       = 300;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 60;
	localparam int TIMEOUT       = 2_000_000;
	localparam int REPORT_LIMIT  = 10;

	// expected result beats and the running peak verdict
	class membership_scoreboard;
		result_t     expected_membership[$];
		bit          peak_so_far;
		int unsigned mismatches;

		function new();
			peak_so_far = 1'b1;
			mismatches  = 0;
		endfunction

		// adjusted position, inside flag, squared distance, peak AND
		function result_t membership_of(item_t it);
			longint          pos, cnt, first_b, last_b, per_q, p, r, e;
			longint unsigned mag, d2;
			bit              in_window;
			result_t         res;
			pos     = $signed(it.position);
			cnt     = $signed(it.aliasing_count);
			first_b = $signed(it.window_first);
			last_b  = $signed(it.window_last);
			per_q   = it.period_points;
			per_q   = per_q << FRACTION_BITS_DEF;
			p       = pos - (longint'(1) << FRACTION_BITS_DEF);
			if (it.fold_allowed) begin
				// fold onto [first, first + period); only the upper bound is tested
				if (per_q != 0) begin
					r = (p - first_b) % per_q;
					if (r < 0)
						r = r + per_q;
					p = first_b + r;
				end
				in_window = (p <= last_b);
			end else begin
				p = p + cnt * per_q;
				in_window = (p >= first_b) && (p <= last_b);
			end
			// distance at twice the scale, squared, then back down
			e   = 2 * p - first_b - last_b;
			mag = (e < 0) ? -e : e;
			if (mag >= (64'd1 << 32)) begin
				d2 = {1'b0, SAT_D2};
			end else begin
				d2 = (mag * mag) >> 2;
				if (d2 > {1'b0, SAT_D2})
					d2 = {1'b0, SAT_D2};
			end
			peak_so_far          = peak_so_far && in_window;
			res.distance_squared = D2_W'(d2);
			res.dimension_inside = in_window;
			res.peak_inside      = peak_so_far;
			res.is_final         = it.final_dimension;
			if (it.final_dimension)
				peak_so_far = 1'b1;
			return res;
		endfunction

		function void note_dimension(item_t it);
			expected_membership.push_back(membership_of(it));
		endfunction

		function void check_membership(result_t got);
			result_t want;
			string   bad;
			bad = "";
			if (expected_membership.size() == 0) begin
				want = '0;
				bad  = "no beat expected";
			end else begin
				want = expected_membership.pop_front();
				if (got.distance_squared != want.distance_squared)
					bad = {bad, " distance_squared"};
				if (got.dimension_inside != want.dimension_inside)
					bad = {bad, " dimension_inside"};
				if (got.peak_inside != want.peak_inside)
					bad = {bad, " peak_inside"};
				if (got.is_final != want.is_final)
					bad = {bad, " is_final"};
			end
			if (bad != "") begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$write("mismatch (%s): expected d2=%h in=%b peak=%b fin=%b,", bad,
						want.distance_squared, want.dimension_inside, want.peak_inside,
						want.is_final);
					$display(" got d2=%h in=%b peak=%b fin=%b", got.distance_squared,
						got.dimension_inside, got.peak_inside, got.is_final);
				end
			end
		endfunction

		function int outstanding();
			return expected_membership.size();
		endfunction

		// failures, counting beats that never came
		function int unsigned close();
			if (expected_membership.size() != 0)
				$display("missing result beats: %0d", expected_membership.size());
			return mismatches + expected_membership.size();
		endfunction
	endclass

	logic    clk;
	logic    arst_n;
	logic    item_valid;
	logic    item_stall;
	item_t   item;
	logic    result_valid;
	logic    result_stall;
	result_t result;

	bit tx_idle = 1'b1;
	bit rx_idle = 1'b1;

	membership_scoreboard sb = new();

	aliased_region_membership_test i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// offer one beat, optionally after a gap, and hold it until taken
	task automatic send_item(input item_t it);
		int gap;
		if ($urandom_range(0, 39) == 0)
			tx_idle = !tx_idle;
		gap = tx_idle ? $urandom_range(0, 4) : 0;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (item_stall)
			@(posedge clk);
		sb.note_dimension(it);
	endtask

	// stop offering and wait for every expected beat
	task automatic wait_all_results();
		item_valid <= 1'b0;
		@(posedge clk);
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	function automatic item_t make_item(input int pos, cnt, first_b, last_b, per,
		input bit fold, fin);
		item_t it;
		it.position        = pos;
		it.aliasing_count  = 8'(cnt);
		it.window_first    = first_b;
		it.window_last     = last_b;
		it.period_points   = 16'(per);
		it.fold_allowed    = fold;
		it.final_dimension = fin;
		return it;
	endfunction

	// every field over its whole range
	function automatic item_t noise_item();
		item_t it;
		it.position        = $urandom;
		it.aliasing_count  = 8'($urandom);
		it.window_first    = $urandom;
		it.window_last     = $urandom;
		it.period_points   = 16'($urandom);
		it.fold_allowed    = 1'($urandom);
		it.final_dimension = 1'($urandom);
		return it;
	endfunction

	// a plausible dimension: position within a few periods of its window
	function automatic item_t random_dimension(input bit fin);
		item_t       it;
		longint      per_q, first_b, last_b, p, off, k;
		int unsigned sel;
		sel = $urandom_range(0, 19);
		if (sel == 0)
			it.period_points = '0;
		else if (sel < 4)
			it.period_points = 16'($urandom_range(1, 65535));
		else
			it.period_points = 16'($urandom_range(1, 300));
		per_q   = it.period_points;
		per_q   = per_q << FRACTION_BITS_DEF;
		first_b = longint'($urandom_range(0, 1 << 25)) - (longint'(1) << 24);
		sel     = $urandom_range(0, 9);
		if (sel < 6)
			last_b = first_b + per_q - 1;
		else if (sel < 9)
			last_b = first_b + longint'($urandom_range(0, 1 << 16));
		else
			last_b = first_b - longint'($urandom_range(1, 1 << 12));
		if (per_q == 0)
			off = longint'($urandom_range(0, 1 << 13)) - (longint'(1) << 12);
		else
			off = longint'($urandom_range(0, 32'(7 * per_q))) - 3 * per_q;
		p                 = first_b + off;
		it.fold_allowed   = 1'($urandom_range(0, 1));
		it.aliasing_count = 8'($urandom_range(0, 8) - 4);
		if (!it.fold_allowed && per_q != 0 && $urandom_range(0, 1) == 1) begin
			// count that brings the peak into the first period from the window start
			k = (p - first_b) / per_q;
			if (p < first_b && ((p - first_b) % per_q) != 0)
				k = k - 1;
			it.aliasing_count = 8'(-k);
		end
		it.position        = 32'(p + (longint'(1) << FRACTION_BITS_DEF));
		it.window_first    = 32'(first_b);
		it.window_last     = 32'(last_b);
		it.final_dimension = fin;
		return it;
	endfunction

	// consumer: random stall per beat, one long hold to back up the block
	initial begin : consumer
		int   wait_left;
		int   taken;
		logic stall_next;
		wait_left = 0;
		taken     = 0;
		result_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			stall_next = result_stall;
			if (result_valid && !result_stall) begin
				taken++;
				if ($urandom_range(0, 39) == 0)
					rx_idle = !rx_idle;
				if (taken == HOLD_AT)
					wait_left = HOLD_CYCLES;
				else
					wait_left = rx_idle ? $urandom_range(0, 4) : 0;
				stall_next = (wait_left > 0);
			end else if (wait_left > 0) begin
				wait_left--;
				stall_next = (wait_left > 0);
			end
			result_stall <= stall_next;
		end
	end

	// result monitor
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall)
			sb.check_membership(result);
	end

	initial begin : stimulus
		int sent;
		int dims;
		bit drained;
		arst_n     <= 1'b0;
		item_valid <= 1'b0;
		item       <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// plain inside, then far outside with saturation closing the peak
		send_item(make_item(32'sh0000_0100, 0, 0, 32'sh0000_1000, 16, 1'b0, 1'b0));
		send_item(make_item(32'sh7fff_ffff, 127, 0, 32'sh7fff_ffff, 65535, 1'b0, 1'b1));
		send_item(make_item(32'sh8000_0000, -128, 32'sh8000_0000, 32'sh7fff_ffff, 65535,
			1'b0, 1'b1));
		// largest distance short of saturation
		send_item(make_item(32'sh7fff_ffff, 0, 0, 0, 1, 1'b0, 1'b1));
		// zero period: no fold, no shift
		send_item(make_item(32'sh0000_2000, 5, 0, 32'sh0000_1000, 0, 1'b1, 1'b0));
		send_item(make_item(32'sh0000_0800, 0, 32'sh0000_1000, 32'sh0000_2000, 0, 1'b1, 1'b1));
		send_item(make_item(32'sh0000_0800, 100, 32'sh0000_1000, 32'sh0000_2000, 0, 1'b0,
			1'b1));
		// fold from below the window, negative remainder
		send_item(make_item(-32'sh0000_1080, 0, 0, 32'sh0000_0100, 1, 1'b1, 1'b0));
		// inverted windows, folded and not
		send_item(make_item(0, 0, 32'sh7fff_ffff, 32'sh8000_0000, 65535, 1'b1, 1'b1));
		send_item(make_item(32'sh0000_0500, 0, 32'sh0000_0800, 32'sh0000_0400, 8, 1'b0, 1'b0));
		// window edges
		send_item(make_item(32'sh0000_1100, 0, 32'sh0000_1000, 32'sh0000_2000, 16, 1'b0, 1'b0));
		send_item(make_item(32'sh0000_2100, 0, 32'sh0000_1000, 32'sh0000_2000, 16, 1'b0, 1'b1));
		send_item(make_item(32'sh0000_2101, 0, 32'sh0000_1000, 32'sh0000_2000, 16, 1'b0, 1'b1));
		// fold to exactly the window start, then fold past the upper bound
		send_item(make_item(32'sh0000_3100, 0, 32'sh0000_1000, 32'sh0000_1fff, 16, 1'b1, 1'b0));
		send_item(make_item(32'sh0000_2000, 0, 32'sh0000_1000, 32'sh0000_1800, 16, 1'b1, 1'b1));
		// aliasing counts bring the peak back in; the last beat folds and ignores its count
		send_item(make_item(32'sh0000_0300, -1, 0, 32'sh0000_0100, 1, 1'b0, 1'b0));
		send_item(make_item(-32240, 127, 0, 32'sh0000_0100, 1, 1'b0, 1'b1));
		send_item(make_item(32'sh0000_0100, -128, 32'sh8000_0000, 0, 65535, 1'b1, 1'b1));

		// random peaks with some noise beats mixed in
		sent    = 0;
		drained = 1'b0;
		while (sent < RANDOM_ITEMS) begin
			if ($urandom_range(0, 6) == 0) begin
				send_item(noise_item());
				sent++;
			end else begin
				dims = $urandom_range(1, 4);
				for (int d = 0; d < dims; d++) begin
					send_item(random_dimension(d == dims - 1));
					sent++;
				end
			end
			if (!drained && sent >= RANDOM_ITEMS / 2) begin
				wait_all_results();
				drained = 1'b1;
			end
		end

		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (sb.close() == 0)
			$display("[aliased_region_membership_test] OK");
		else
			$display("[aliased_region_membership_test] ERROR");
		$finish;
	end

	initial begin : watchdog
		#(TIMEOUT);
		$display("timeout");
		$display("[aliased_region_membership_test] ERROR");
		$finish;
	end

endmodule
